@@ src/sorted_union_merge_core_assert.svh @@
// Assertion macros shared by the sorted union merge core.
`ifndef SORTED_UNION_MERGE_CORE_ASSERT_SVH
`define SORTED_UNION_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SUMERGE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SUMERGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sumerge_pkg.sv @@
`timescale 1ns / 1ps

package sumerge_pkg;

  // Defaults for the top-level parameters.
  localparam int LIST_DEPTH_DEF = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Input mode codes.
  localparam logic [1:0] MODE_APPEND_A = 2'd0;
  localparam logic [1:0] MODE_APPEND_B = 2'd1;
  localparam logic [1:0] MODE_MERGE    = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic merge_start;
    logic pick;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_a;
    logic have_b;
  } status_t;

endpackage

@@ src/sorted_union_merge_core.sv @@
`timescale 1ns / 1ps

// Sorted union merge core. Items are accepted when start is high and busy is
// low. An append (in_mode 0 or 1) leaves busy low, so loads can stream one
// item per cycle; appends to a full list are dropped and flagged in
// out_overflowed on every result of the next merge. A merge (in_mode 2) holds
// busy high through S two-pointer steps and a final flush, where S is at
// most the sum of the two list counts; each step is a list memory read
// followed by a compare and pointer update. Results leave on
// out_strobe for exactly one cycle each, at most one per step, and cannot be
// held off: the receiver must take every strobed result. The final result has
// out_last set; when both lists are empty a single result with out_empty_union
// and out_last set is given. Both lists are cleared when the merge finishes.
module sorted_union_merge_core #(
  parameter int LIST_DEPTH = sumerge_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = sumerge_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic signed [31:0] out_union_value,
  output logic               out_last,
  output logic               out_empty_union,
  output logic               out_overflowed
);

  sumerge_pkg::cmd_t    cmd;
  sumerge_pkg::status_t status;

  // Sequencer.
  sumerge_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .cmd     (cmd),
    .status  (status)
  );

  // List stores, pointers and result registers.
  sumerge_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .status          (status),
    .out_strobe      (out_strobe),
    .out_union_value (out_union_value),
    .out_last        (out_last),
    .out_empty_union (out_empty_union),
    .out_overflowed  (out_overflowed)
  );

endmodule

@@ src/sumerge_ctrl.sv @@
`timescale 1ns / 1ps

module sumerge_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_mode,
  output logic                 busy,
  output sumerge_pkg::cmd_t    cmd,
  input  sumerge_pkg::status_t status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_PICK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Sequencing: loads finish in idle, a merge alternates read and pick, then flushes.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            sumerge_pkg::MODE_APPEND_A: cmd.load_a = 1'b1;
            sumerge_pkg::MODE_APPEND_B: cmd.load_b = 1'b1;
            sumerge_pkg::MODE_MERGE: begin
              cmd.merge_start = 1'b1;
              state_nxt       = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (status.have_a || status.have_b) begin
          state_nxt = ST_PICK;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ src/sumerge_dp.sv @@
`timescale 1ns / 1ps
`include "sorted_union_merge_core_assert.svh"

module sumerge_dp #(
  parameter int LIST_DEPTH = sumerge_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = sumerge_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [31:0]    in_value,
  input  sumerge_pkg::cmd_t     cmd,
  output sumerge_pkg::status_t  status,
  output logic                  out_strobe,
  output logic signed [31:0]    out_union_value,
  output logic                  out_last,
  output logic                  out_empty_union,
  output logic                  out_overflowed
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int XW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [VALUE_BITS-1:0] mem_a [LIST_DEPTH];
  logic [VALUE_BITS-1:0] mem_b [LIST_DEPTH];
  logic [VALUE_BITS-1:0] rd_a_r, rd_b_r;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ptr_a_r, ptr_a_nxt, ptr_b_r, ptr_b_nxt;
  logic          drop_r, drop_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [VALUE_BITS-1:0] pend_val_r, pend_val_nxt;

  logic          strobe_r, strobe_nxt;
  logic [VALUE_BITS-1:0] oval_r, oval_nxt;
  logic          olast_r, olast_nxt, oempty_r, oempty_nxt, oflow_r, oflow_nxt;

  logic signed [XW-1:0] in_ext;
  logic [VALUE_BITS-1:0] in_keep;
  logic [XW-1:0] oval_ext;
  logic          full_a, full_b;
  logic          take_a, take_b, is_new;
  logic [VALUE_BITS-1:0] cand;

  // Incoming values are sign-extended or cut to the stored width.
  assign in_ext  = XW'(in_value);
  assign in_keep = in_ext[VALUE_BITS-1:0];
  assign full_a  = (cnt_a_r >= DEPTH_C);
  assign full_b  = (cnt_b_r >= DEPTH_C);

  // List stores: one write port at the fill count, one registered read at the pointer.
  always_ff @(posedge clk) begin
    if (cmd.load_a && !full_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_keep;
    end
    if (cmd.load_b && !full_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_keep;
    end
    rd_a_r <= mem_a[ptr_a_r[AW-1:0]];
    rd_b_r <= mem_b[ptr_b_r[AW-1:0]];
  end

  assign status.have_a = (ptr_a_r < cnt_a_r);
  assign status.have_b = (ptr_b_r < cnt_b_r);

  // Two-pointer choice: the smaller head advances, equal heads advance together.
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    cand   = rd_a_r;
    if (status.have_a && status.have_b) begin
      if ($signed(rd_a_r) < $signed(rd_b_r)) begin
        take_a = 1'b1;
      end else if ($signed(rd_b_r) < $signed(rd_a_r)) begin
        take_b = 1'b1;
        cand   = rd_b_r;
      end else begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
    end else if (status.have_a) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
      cand   = rd_b_r;
    end
  end

  assign is_new = !pend_valid_r || (cand != pend_val_r);

  // Register updates. A distinct value is held back one step so that the
  // final one can carry the last flag.
  always_comb begin
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ptr_a_nxt      = ptr_a_r;
    ptr_b_nxt      = ptr_b_r;
    drop_nxt       = drop_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    strobe_nxt     = 1'b0;
    oval_nxt       = oval_r;
    olast_nxt      = 1'b0;
    oempty_nxt     = 1'b0;
    oflow_nxt      = oflow_r;

    if (cmd.load_a) begin
      if (full_a) begin
        drop_nxt = 1'b1;
      end else begin
        cnt_a_nxt = cnt_a_r + 1'b1;
      end
    end
    if (cmd.load_b) begin
      if (full_b) begin
        drop_nxt = 1'b1;
      end else begin
        cnt_b_nxt = cnt_b_r + 1'b1;
      end
    end
    if (cmd.merge_start) begin
      ptr_a_nxt      = '0;
      ptr_b_nxt      = '0;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.pick) begin
      if (take_a) ptr_a_nxt = ptr_a_r + 1'b1;
      if (take_b) ptr_b_nxt = ptr_b_r + 1'b1;
      if (is_new) begin
        pend_valid_nxt = 1'b1;
        pend_val_nxt   = cand;
        if (pend_valid_r) begin
          strobe_nxt = 1'b1;
          oval_nxt   = pend_val_r;
          oflow_nxt  = drop_r;
        end
      end
    end
    if (cmd.flush) begin
      strobe_nxt     = 1'b1;
      olast_nxt      = 1'b1;
      oempty_nxt     = !pend_valid_r;
      oval_nxt       = pend_valid_r ? pend_val_r : '0;
      oflow_nxt      = drop_r;
      cnt_a_nxt      = '0;
      cnt_b_nxt      = '0;
      ptr_a_nxt      = '0;
      ptr_b_nxt      = '0;
      drop_nxt       = 1'b0;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ptr_a_r      <= '0;
      ptr_b_r      <= '0;
      drop_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ptr_a_r      <= ptr_a_nxt;
      ptr_b_r      <= ptr_b_nxt;
      drop_r       <= drop_nxt;
      pend_valid_r <= pend_valid_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    oval_r     <= oval_nxt;
    olast_r    <= olast_nxt;
    oempty_r   <= oempty_nxt;
    oflow_r    <= oflow_nxt;
  end

  // The result carries the low 32 bits of the stored value, zero-extended.
  assign oval_ext        = XW'(oval_r);
  assign out_strobe      = strobe_r;
  assign out_union_value = $signed(oval_ext[31:0]);
  assign out_last        = olast_r;
  assign out_empty_union = oempty_r;
  assign out_overflowed  = oflow_r;

  `SUMERGE_ASSERT_NOW(a_empty_is_last, clk, rst_n, out_strobe && out_empty_union, out_last, "empty result without last flag")
  `SUMERGE_ASSERT_NOW(a_pick_has_head, clk, rst_n, cmd.pick, status.have_a || status.have_b, "pick with both lists exhausted")
  `SUMERGE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, (cnt_a_r <= DEPTH_C) && (cnt_b_r <= DEPTH_C), "list count beyond depth")
  `SUMERGE_ASSERT_NEXT(a_flush_clears, clk, rst_n, cmd.flush, (cnt_a_r == '0) && (cnt_b_r == '0) && !drop_r && out_strobe && out_last, "flush did not clear lists or emit last")

endmodule
